[rtl/core/stereo_peak_rms_meter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stereo peak/RMS meter
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAK_RMS_METER_UNIT_MACROS_SVH
`define STEREO_PEAK_RMS_METER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPMR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/spmr_pkg.sv]
// ----------------------------------------------------------------------------
// spmr_pkg
// Types, codes and constants shared by the stereo peak/RMS meter.
// ----------------------------------------------------------------------------
package spmr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int PROD_W   = 32;
  localparam int MEAN_W   = 31;
  localparam int RAD_W    = 32;
  localparam int CFG_W    = 16;

  localparam logic [RAD_W-1:0]   ROOT_INIT_BIT = 32'h4000_0000;
  localparam logic [3:0]         SQRT_LAST     = 4'd15;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 16'h8000;

  // configuration register indexes
  localparam logic CFG_CHANNELS = 1'b0;
  localparam logic CFG_DECAY    = 1'b1;

  // channels_in_use codes
  localparam logic [1:0] CH_NONE = 2'd0;
  localparam logic [1:0] CH_MONO = 2'd1;

  localparam logic [1:0]       CH_RESET    = 2'd2;
  localparam logic [CFG_W-1:0] DECAY_RESET = 16'd65529;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_START,
    ST_ROOT,
    ST_OUT
  } meter_state_e;

  typedef enum logic [2:0] {
    MS_LPEAK,
    MS_RPEAK,
    MS_LOLD,
    MS_ROLD,
    MS_LNEW,
    MS_RNEW
  } mul_step_e;

  typedef enum logic [1:0] {
    RMS_IDLE,
    RMS_SQRT
  } rms_state_e;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } spmr_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] peak_left;
    logic [LEVEL_W-1:0] peak_right;
    logic [LEVEL_W-1:0] rms_left;
    logic [LEVEL_W-1:0] rms_right;
  } spmr_out_t;

  // magnitude of a Q1.15 sample; -32768 maps to 32768
  function automatic logic [SAMPLE_W-1:0] spmr_mag(logic [SAMPLE_W-1:0] x);
    logic [SAMPLE_W-1:0] neg;
    neg = ~x + 16'd1;
    return x[SAMPLE_W-1] ? neg : x;
  endfunction

endpackage

[rtl/core/stereo_peak_rms_meter_unit.sv]
// ----------------------------------------------------------------------------
// stereo_peak_rms_meter_unit
// Stereo peak-hold and sliding-window RMS level meter on Q1.15 samples.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ------------------------------------
//  in        in_valid_i / in_ready_o   in_data_i: command, left, right
//  out       out_valid_o / out_ready_i out_data_o: peaks and RMS levels
//  cfg       cfg_we_i (no wait)        cfg_index_i, cfg_wdata_i
//
//  A sample request holds in_ready_o low from acceptance until its result
//  is loaded, so no new sample is taken before then: six passes through
//  the shared 16x16 multiplier, one to settle the sums, one to start the
//  RMS units, 16 square-root steps, one to see them done and one to load
//  the result. A clear-peak request holds in_ready_o low until its result
//  is loaded. After reset a clearing pass zeroes every window RAM entry
//  with in_ready_o low; configuration writes are taken throughout.
//  A finished result waits in the output register; the block stalls only when
//  a new result is ready and the previous one has not been taken.
//
`include "stereo_peak_rms_meter_unit_macros.svh"

module stereo_peak_rms_meter_unit #(
  parameter int WINDOW_LENGTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  spmr_pkg::spmr_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output spmr_pkg::spmr_out_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [spmr_pkg::CFG_W-1:0] cfg_wdata_i
);

  import spmr_pkg::*;

  localparam int POS_W  = $clog2(WINDOW_LENGTH);
  localparam int SUM_W  = POS_W + MEAN_W;
  localparam int WORD_W = 2 * SAMPLE_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LENGTH - 1);

  // control state
  meter_state_e        state_q, state_d;
  mul_step_e           mstep_q, mstep_d;
  mul_step_e           pstep_q, pstep_d;
  logic                prod_vld_q, prod_vld_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    pos_next;
  logic [1:0]          ch_q, ch_d;
  logic [CFG_W-1:0]    decay_q, decay_d;
  logic                out_valid_q, out_valid_d;

  // meter state
  logic [LEVEL_W-1:0]  lhold_q, lhold_d;
  logic [LEVEL_W-1:0]  rhold_q, rhold_d;
  logic [SUM_W-1:0]    lsum_q, lsum_d;
  logic [SUM_W-1:0]    rsum_q, rsum_d;

  // payload
  logic [SAMPLE_W-1:0] l_q, l_d;
  logic [SAMPLE_W-1:0] r_q, r_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  spmr_out_t           out_q, out_d;

  // datapath
  logic [SAMPLE_W-1:0] mul_a, mul_b;
  logic [SAMPLE_W-1:0] mag_l, mag_r;
  logic [SAMPLE_W-1:0] mag_old_l, mag_old_r;
  logic [LEVEL_W-1:0]  decayed;
  logic                ram_we, ram_re;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic                rms_start;
  logic                rms_done_l, rms_done_r;
  logic [LEVEL_W-1:0]  rms_level_l, rms_level_r;
  logic                out_load;

  // window store: left sample in the upper half, right in the lower
  spmr_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WINDOW_LENGTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(pos_q),
    .rdata_o(ram_rdata)
  );

  spmr_rms #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_rms_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(rms_start),
    .sum_i  (lsum_q),
    .done_o (rms_done_l),
    .level_o(rms_level_l)
  );

  spmr_rms #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_rms_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(rms_start),
    .sum_i  (rsum_q),
    .done_o (rms_done_r),
    .level_o(rms_level_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mstep_q     <= MS_LPEAK;
      pstep_q     <= MS_LPEAK;
      prod_vld_q  <= 1'b0;
      pos_q       <= '0;
      ch_q        <= CH_RESET;
      decay_q     <= DECAY_RESET;
      out_valid_q <= 1'b0;
      lhold_q     <= '0;
      rhold_q     <= '0;
      lsum_q      <= '0;
      rsum_q      <= '0;
    end else begin
      state_q     <= state_d;
      mstep_q     <= mstep_d;
      pstep_q     <= pstep_d;
      prod_vld_q  <= prod_vld_d;
      pos_q       <= pos_d;
      ch_q        <= ch_d;
      decay_q     <= decay_d;
      out_valid_q <= out_valid_d;
      lhold_q     <= lhold_d;
      rhold_q     <= rhold_d;
      lsum_q      <= lsum_d;
      rsum_q      <= rsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q    <= l_d;
    r_q    <= r_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  // configuration writes
  always_comb begin
    ch_d    = ch_q;
    decay_d = decay_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CHANNELS: ch_d    = cfg_wdata_i[1:0];
        CFG_DECAY:    decay_d = cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  assign mag_l     = spmr_mag(l_q);
  assign mag_r     = spmr_mag(r_q);
  assign mag_old_l = spmr_mag(ram_rdata[WORD_W-1:SAMPLE_W]);
  assign mag_old_r = spmr_mag(ram_rdata[SAMPLE_W-1:0]);
  assign pos_next  = (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);

  // shared multiplier operands: decays first, then old and new squares
  always_comb begin
    case (mstep_q)
      MS_LPEAK: begin
        mul_a = lhold_q;
        mul_b = decay_q;
      end
      MS_RPEAK: begin
        mul_a = rhold_q;
        mul_b = decay_q;
      end
      MS_LOLD: begin
        mul_a = mag_old_l;
        mul_b = mag_old_l;
      end
      MS_ROLD: begin
        mul_a = mag_old_r;
        mul_b = mag_old_r;
      end
      MS_LNEW: begin
        mul_a = mag_l;
        mul_b = mag_l;
      end
      MS_RNEW: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign decayed = prod_q[PROD_W-1:SAMPLE_W];

  // next state, control and datapath
  always_comb begin
    state_d     = state_q;
    mstep_d     = mstep_q;
    pstep_d     = mstep_q;
    prod_vld_d  = 1'b0;
    pos_d       = pos_q;
    lhold_d     = lhold_q;
    rhold_d     = rhold_q;
    lsum_d      = lsum_q;
    rsum_d      = rsum_q;
    l_d         = l_q;
    r_d         = r_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = {l_q, r_q};
    in_ready_o  = 1'b0;
    rms_start   = 1'b0;
    out_load    = 1'b0;

    // consume the product registered in the previous cycle
    if (prod_vld_q) begin
      case (pstep_q)
        MS_LPEAK: lhold_d = (mag_l > decayed) ? mag_l : decayed;
        MS_RPEAK: rhold_d = (mag_r > decayed) ? mag_r : decayed;
        MS_LOLD:  lsum_d  = lsum_q - SUM_W'(prod_q);
        MS_ROLD:  rsum_d  = rsum_q - SUM_W'(prod_q);
        MS_LNEW:  lsum_d  = lsum_q + SUM_W'(prod_q);
        MS_RNEW:  rsum_d  = rsum_q + SUM_W'(prod_q);
        default:  ;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        // zero the window store, one entry a cycle
        ram_we    = 1'b1;
        ram_wdata = '0;
        pos_d     = pos_next;
        if (pos_q == POS_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.command) begin
            // clear-peak request: drop both holds, keep window and levels
            lhold_d = '0;
            rhold_d = '0;
            state_d = ST_OUT;
          end else begin
            // fetch the oldest samples while latching the new ones
            ram_re = 1'b1;
            case (ch_q)
              CH_NONE: begin
                l_d = '0;
                r_d = '0;
              end
              CH_MONO: begin
                l_d = in_data_i.left_sample;
                r_d = in_data_i.left_sample;
              end
              default: begin
                l_d = in_data_i.left_sample;
                r_d = in_data_i.right_sample;
              end
            endcase
            mstep_d = MS_LPEAK;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_vld_d = 1'b1;
        case (mstep_q)
          MS_LPEAK: begin
            // old samples are held in the read register; overwrite the slot
            ram_we  = 1'b1;
            pos_d   = pos_next;
            mstep_d = MS_RPEAK;
          end
          MS_RPEAK: mstep_d = MS_LOLD;
          MS_LOLD:  mstep_d = MS_ROLD;
          MS_ROLD:  mstep_d = MS_LNEW;
          MS_LNEW:  mstep_d = MS_RNEW;
          MS_RNEW:  state_d = ST_ACC;
          default:  state_d = ST_ACC;
        endcase
      end
      ST_ACC: begin
        // last product lands in the sums this cycle
        state_d = ST_START;
      end
      ST_START: begin
        rms_start = 1'b1;
        state_d   = ST_ROOT;
      end
      ST_ROOT: begin
        if (rms_done_l) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d.peak_left  = lhold_q;
      out_d.peak_right = rhold_q;
      out_d.rms_left   = rms_level_l;
      out_d.rms_right  = rms_level_r;
      out_valid_d      = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SPMR_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= POS_LAST, "window position out of range")
  `SPMR_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o,
    "request accepted while another is in work")
  `SPMR_ASSERT_NOW(a_roots_aligned, 1'b1, rms_done_l == rms_done_r,
    "left and right rms units out of step")
  `SPMR_ASSERT_NOW(a_peak_range, 1'b1, lhold_q <= LEVEL_MAX && rhold_q <= LEVEL_MAX,
    "peak hold above full scale")

endmodule

[rtl/core/spmr_ram.sv]
// ----------------------------------------------------------------------------
// spmr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data between reads
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/spmr_rms.sv]
// ----------------------------------------------------------------------------
// spmr_rms
// One channel's RMS level: bitwise square root of the window mean, with the
// window length folded into the root steps.
// ----------------------------------------------------------------------------
`include "stereo_peak_rms_meter_unit_macros.svh"

module spmr_rms #(
  parameter int WINDOW_LENGTH = 1024
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [$clog2(WINDOW_LENGTH)+spmr_pkg::MEAN_W-1:0] sum_i,
  output logic                                         done_o,
  output logic [spmr_pkg::LEVEL_W-1:0]                 level_o
);

  import spmr_pkg::*;

  localparam int POS_W = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = POS_W + MEAN_W;
  // first trial bit of the root, scaled by the window length
  localparam logic [SUM_W-1:0] WBIT_INIT = SUM_W'(WINDOW_LENGTH) << (MEAN_W - 1);

  rms_state_e          state_q, state_d;
  logic [SUM_W-1:0]    rad_q, rad_d;
  logic [SUM_W-1:0]    wroot_q, wroot_d;
  logic [SUM_W-1:0]    wbit_q, wbit_d;
  logic [RAD_W-1:0]    root_q, root_d;
  logic [RAD_W-1:0]    bit_q, bit_d;
  logic [3:0]          scnt_q, scnt_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic                done_q, done_d;
  logic [SUM_W-1:0]    trial;
  logic                sqrt_ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RMS_IDLE;
      level_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q   <= rad_d;
    wroot_q <= wroot_d;
    wbit_q  <= wbit_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
    scnt_q  <= scnt_d;
  end

  // compare the raw sum against window length times the trial root
  assign trial   = wroot_q + wbit_q;
  assign sqrt_ge = rad_q >= trial;

  always_comb begin
    state_d = state_q;
    rad_d   = rad_q;
    wroot_d = wroot_q;
    wbit_d  = wbit_q;
    root_d  = root_q;
    bit_d   = bit_q;
    scnt_d  = scnt_q;
    level_d = level_q;
    done_d  = 1'b0;
    case (state_q)
      RMS_IDLE: begin
        if (start_i) begin
          rad_d   = sum_i;
          wroot_d = '0;
          wbit_d  = WBIT_INIT;
          root_d  = '0;
          bit_d   = ROOT_INIT_BIT;
          scnt_d  = SQRT_LAST;
          state_d = RMS_SQRT;
        end
      end
      RMS_SQRT: begin
        // root stays even before each halving, so the scaled copy halves exactly
        rad_d   = sqrt_ge ? rad_q - trial : rad_q;
        wroot_d = sqrt_ge ? (wroot_q >> 1) + wbit_q : wroot_q >> 1;
        wbit_d  = wbit_q >> 2;
        root_d  = sqrt_ge ? (root_q >> 1) + bit_q : root_q >> 1;
        bit_d   = bit_q >> 2;
        scnt_d  = scnt_q - 4'd1;
        if (scnt_q == '0) begin
          level_d = root_d[LEVEL_W-1:0];
          done_d  = 1'b1;
          state_d = RMS_IDLE;
        end
      end
      default: begin
        state_d = RMS_IDLE;
      end
    endcase
  end

  assign done_o  = done_q;
  assign level_o = level_q;

  `SPMR_ASSERT_NOW(a_start_when_idle, start_i, state_q == RMS_IDLE, "rms start while busy")
  `SPMR_ASSERT_NOW(a_level_range, 1'b1, level_q <= LEVEL_MAX, "rms level above full scale")
  `SPMR_ASSERT_NOW(a_done_idle, done_o, state_q == RMS_IDLE, "rms done while still busy")

endmodule
